/* sv/fhp_pkg.sv */
package fhp_pkg;

  localparam int INFO_BYTES = 18;
  localparam int INFO_STORE = INFO_BYTES - 1;
  localparam int INFO_IDX_W = $clog2(INFO_STORE);
  localparam int INFO_BITS  = INFO_BYTES * 8;
  localparam int CNT_W      = 24;
  localparam int MAGIC_LEN  = 4;
  localparam int HDR_LEN    = 4;

  localparam int MBS_POS   = 16;
  localparam int MBS_LEN   = 16;
  localparam int MINF_POS  = 32;
  localparam int MAXF_POS  = 56;
  localparam int FRAME_LEN = 24;
  localparam int RATE_POS  = 80;
  localparam int RATE_LEN  = 20;
  localparam int CH_POS    = 100;
  localparam int CH_LEN    = 3;
  localparam int BITS_POS  = 103;
  localparam int BITS_LEN  = 5;
  localparam int TOT_POS   = 108;
  localparam int TOT_LEN   = 36;

  localparam logic [5:0] MIN_VALID_BITS = 6'd8;

  localparam logic [7:0] MAGIC_F  = 8'h66;
  localparam logic [7:0] MAGIC_LL = 8'h4C;
  localparam logic [7:0] MAGIC_A  = 8'h61;
  localparam logic [7:0] MAGIC_CC = 8'h43;

  localparam logic [1:0] CFG_MIN_CH   = 2'd0;
  localparam logic [1:0] CFG_MAX_CH   = 2'd1;
  localparam logic [1:0] CFG_MIN_BITS = 2'd2;
  localparam logic [1:0] CFG_MAX_BITS = 2'd3;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_MAGIC = 6'b000010,
    PH_HDR   = 6'b000100,
    PH_SKIP  = 6'b001000,
    PH_INFO  = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MAGIC = 3'd1,
    ST_NO_INFO   = 3'd2,
    ST_BAD_FIELD = 3'd3,
    ST_LIMIT     = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } in_word_t;

  typedef struct packed {
    logic [3:0] min_channels;
    logic [3:0] max_channels;
    logic [5:0] min_sample_bits;
    logic [5:0] max_sample_bits;
  } limits_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] max_block_size;
    logic [23:0] min_frame_size;
    logic [23:0] max_frame_size;
    logic [19:0] sample_rate;
    logic [3:0]  channels;
    logic [5:0]  sample_bits;
    logic [35:0] total_samples;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0:    m = MAGIC_F;
      2'd1:    m = MAGIC_LL;
      2'd2:    m = MAGIC_A;
      default: m = MAGIC_CC;
    endcase
    return m;
  endfunction

endpackage

/* sv/fhp_in_reg.sv */
module fhp_in_reg
  import fhp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_word,
  output logic     word_valid,
  output in_word_t word,
  input  logic     word_take
);

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;

  assign in_ready   = !valid_r || word_take;
  assign word_valid = valid_r;
  assign word       = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (word_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

endmodule

/* sv/fhp_unpack.sv */
module fhp_unpack
  import fhp_pkg::*;
(
  input  logic [INFO_STORE-1:0][7:0] info,
  input  logic [7:0]                 last_byte,
  input  limits_t                    limits,
  output result_t                    res
);

  logic [INFO_BITS-1:0] v;
  logic [3:0]           ch;
  logic [5:0]           bits;
  logic                 bad_field;
  logic                 out_limit;

  always_comb begin
    for (int i = 0; i < INFO_STORE; i++) begin
      v[INFO_BITS-1-8*i -: 8] = info[i];
    end
    v[7:0] = last_byte;
  end

  assign ch   = {1'b0, v[INFO_BITS-1-CH_POS -: CH_LEN]} + 4'd1;
  assign bits = {1'b0, v[INFO_BITS-1-BITS_POS -: BITS_LEN]} + 6'd1;

  assign bad_field = (v[INFO_BITS-1-RATE_POS -: RATE_LEN] == '0) ||
                     (v[INFO_BITS-1-TOT_POS -: TOT_LEN] == '0) ||
                     (bits < MIN_VALID_BITS);
  assign out_limit = (ch < limits.min_channels) || (ch > limits.max_channels) ||
                     (bits < limits.min_sample_bits) || (bits > limits.max_sample_bits);

  always_comb begin
    priority if (bad_field) begin
      res.status = ST_BAD_FIELD;
    end else if (out_limit) begin
      res.status = ST_LIMIT;
    end else begin
      res.status = ST_OK;
    end
    res.max_block_size = v[INFO_BITS-1-MBS_POS -: MBS_LEN];
    res.min_frame_size = v[INFO_BITS-1-MINF_POS -: FRAME_LEN];
    res.max_frame_size = v[INFO_BITS-1-MAXF_POS -: FRAME_LEN];
    res.sample_rate    = v[INFO_BITS-1-RATE_POS -: RATE_LEN];
    res.channels       = ch;
    res.sample_bits    = bits;
    res.total_samples  = v[INFO_BITS-1-TOT_POS -: TOT_LEN];
  end

endmodule

/* sv/fhp_parser.sv */
module fhp_parser
  import fhp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     word_valid,
  input  in_word_t word,
  input  logic     out_free,
  input  limits_t  limits,
  output logic     word_take,
  output logic     emit,
  output result_t  res
);

  phase_t                    phase_r;
  phase_t                    phase_nxt;
  logic [CNT_W-1:0]          cnt_r;
  logic [CNT_W-1:0]          cnt_nxt;
  logic                      last_r;
  logic                      last_nxt;
  logic [31:0]               hs_r;
  logic [31:0]               hs_nxt;
  logic [INFO_STORE-1:0][7:0] info_r;

  phase_t           ph;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_inc;
  logic             last;
  logic [31:0]      hs;
  logic [31:0]      hs_sh;
  logic [7:0]       b;
  logic             fail;
  status_t          fail_code;
  logic             info_done;
  logic             info_wr;
  result_t          info_res;

  fhp_unpack u_unpack (
    .info      (info_r),
    .last_byte (word.data_byte),
    .limits    (limits),
    .res       (info_res)
  );

  assign b       = word.data_byte;
  assign ph      = word.start_req ? PH_MAGIC : phase_r;
  assign cnt     = word.start_req ? '0 : cnt_r;
  assign last    = word.start_req ? 1'b0 : last_r;
  assign hs      = word.start_req ? '0 : hs_r;
  assign hs_sh   = {hs[23:0], b};
  assign cnt_inc = cnt + 1'b1;

  always_comb begin
    phase_nxt = ph;
    cnt_nxt   = cnt;
    last_nxt  = last;
    hs_nxt    = hs;
    fail      = 1'b0;
    fail_code = ST_NO_INFO;
    info_done = 1'b0;
    info_wr   = 1'b0;
    unique case (ph)
      PH_MAGIC: begin
        if (b != magic_byte(cnt[1:0])) begin
          fail      = 1'b1;
          fail_code = ST_BAD_MAGIC;
          phase_nxt = PH_DONE;
        end else if (cnt_inc == CNT_W'(MAGIC_LEN)) begin
          phase_nxt = PH_HDR;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_HDR: begin
        hs_nxt = hs_sh;
        if (cnt_inc != CNT_W'(HDR_LEN)) begin
          cnt_nxt = cnt_inc;
        end else begin
          last_nxt = hs_sh[31];
          cnt_nxt  = '0;
          if (hs_sh[23:0] == '0) begin
            if (hs_sh[31]) begin
              fail      = 1'b1;
              phase_nxt = PH_DONE;
            end
          end else if (hs_sh[30:24] == '0) begin
            phase_nxt = PH_INFO;
          end else begin
            phase_nxt = PH_SKIP;
            cnt_nxt   = hs_sh[23:0];
          end
        end
      end
      PH_SKIP: begin
        cnt_nxt = cnt - 1'b1;
        if (cnt_nxt == '0) begin
          if (last) begin
            fail      = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_HDR;
          end
        end
      end
      PH_INFO: begin
        if (cnt == CNT_W'(INFO_STORE)) begin
          info_done = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          info_wr = 1'b1;
          cnt_nxt = cnt_inc;
        end
      end
      default: begin
      end
    endcase
  end

  assign emit      = word_valid && (fail || info_done);
  assign word_take = word_valid && (!emit || out_free);

  always_comb begin
    if (fail) begin
      res        = '0;
      res.status = fail_code;
    end else begin
      res = info_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      last_r  <= 1'b0;
      hs_r    <= '0;
    end else if (word_take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      hs_r    <= hs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (word_take && info_wr) begin
      info_r[cnt[INFO_IDX_W-1:0]] <= b;
    end
  end

endmodule

/* sv/flac_stream_header_parser_core.sv */
// An accepted byte is captured in the input register; its result, if any, is then loaded
// into the output register when that register is free.
// Throughput: one byte per cycle; the input stage stalls only while a result is held
// in the output register and not taken.
// Reset: synchronous, active low; clears the handshake state, the parser phase and
// counters, and sets the limit registers to their defaults. No clearing pass is run.
module flac_stream_header_parser_core
  import fhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_max_block_size,
  output logic [23:0] out_min_frame_size,
  output logic [23:0] out_max_frame_size,
  output logic [19:0] out_sample_rate,
  output logic [3:0]  out_channels,
  output logic [5:0]  out_sample_bits,
  output logic [35:0] out_total_samples,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  limits_t  limits_r;
  in_word_t in_word;
  in_word_t word;
  logic     word_valid;
  logic     word_take;
  logic     emit;
  logic     out_free;
  result_t  res;
  logic     out_valid_r;
  logic     out_valid_nxt;
  result_t  out_res_r;

  assign in_word.data_byte = in_data_byte;
  assign in_word.start_req = in_start_req;

  fhp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .word_valid (word_valid),
    .word       (word),
    .word_take  (word_take)
  );

  fhp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (word_valid),
    .word       (word),
    .out_free   (out_free),
    .limits     (limits_r),
    .word_take  (word_take),
    .emit       (emit),
    .res        (res)
  );

  // hold the limits between writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.min_channels    <= 4'd1;
      limits_r.max_channels    <= 4'd8;
      limits_r.min_sample_bits <= 6'd8;
      limits_r.max_sample_bits <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_CH:   limits_r.min_channels    <= cfg_data[3:0];
        CFG_MAX_CH:   limits_r.max_channels    <= cfg_data[3:0];
        CFG_MIN_BITS: limits_r.min_sample_bits <= cfg_data;
        CFG_MAX_BITS: limits_r.max_sample_bits <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit && word_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && word_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_max_block_size = out_res_r.max_block_size;
  assign out_min_frame_size = out_res_r.min_frame_size;
  assign out_max_frame_size = out_res_r.max_frame_size;
  assign out_sample_rate    = out_res_r.sample_rate;
  assign out_channels       = out_res_r.channels;
  assign out_sample_bits    = out_res_r.sample_bits;
  assign out_total_samples  = out_res_r.total_samples;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import fhp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 255;
  localparam int N_PHASES    = 6;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 8;

  localparam logic [7:0] MAGIC_SEQ [MAGIC_LEN] = '{MAGIC_F, MAGIC_LL, MAGIC_A, MAGIC_CC};

  typedef struct packed {
    logic       st;
    logic [7:0] b;
    logic       typed;
    status_t    code;
  } dir_row_t;

  localparam dir_row_t DIRECTED [24] = '{
    '{1'b0, 8'h00, 1'b0, ST_OK},
    '{1'b1, 8'hFF, 1'b1, ST_BAD_MAGIC},
    '{1'b1, MAGIC_F, 1'b0, ST_OK},
    '{1'b0, MAGIC_LL, 1'b0, ST_OK},
    '{1'b0, MAGIC_A, 1'b0, ST_OK},
    '{1'b0, 8'h42, 1'b1, ST_BAD_MAGIC},
    '{1'b0, 8'h5A, 1'b0, ST_OK},
    '{1'b1, MAGIC_F, 1'b0, ST_OK},
    '{1'b0, MAGIC_LL, 1'b0, ST_OK},
    '{1'b0, MAGIC_A, 1'b0, ST_OK},
    '{1'b0, MAGIC_CC, 1'b0, ST_OK},
    '{1'b0, 8'h80, 1'b0, ST_OK},
    '{1'b0, 8'h00, 1'b0, ST_OK},
    '{1'b0, 8'h00, 1'b0, ST_OK},
    '{1'b0, 8'h00, 1'b1, ST_NO_INFO},
    '{1'b1, MAGIC_F, 1'b0, ST_OK},
    '{1'b0, MAGIC_LL, 1'b0, ST_OK},
    '{1'b0, MAGIC_A, 1'b0, ST_OK},
    '{1'b0, MAGIC_CC, 1'b0, ST_OK},
    '{1'b0, 8'hFF, 1'b0, ST_OK},
    '{1'b0, 8'h00, 1'b0, ST_OK},
    '{1'b0, 8'h00, 1'b0, ST_OK},
    '{1'b0, 8'h01, 1'b0, ST_OK},
    '{1'b0, 8'h00, 1'b1, ST_NO_INFO}
  };

  localparam limits_t LIMIT_SETS [4] = '{
    '{4'd1, 4'd8, 6'd1, 6'd32},
    '{4'd2, 4'd2, 6'd16, 6'd16},
    '{4'd8, 4'd8, 6'd32, 6'd32},
    '{4'd5, 4'd3, 6'd20, 6'd10}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_start_req;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [15:0] out_max_block_size;
  logic [23:0] out_min_frame_size;
  logic [23:0] out_max_frame_size;
  logic [19:0] out_sample_rate;
  logic [3:0]  out_channels;
  logic [5:0]  out_sample_bits;
  logic [35:0] out_total_samples;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_data;

  phase_t      ph        = PH_IDLE;
  logic [23:0] cnt       = '0;
  logic        last_blk  = 1'b0;
  logic [6:0]  blk_kind  = '0;
  logic [31:0] hdr_sr    = '0;
  logic [7:0]  info_mem [INFO_BYTES];
  limits_t     lim       = '{4'd1, 4'd8, 6'd8, 6'd32};

  result_t     pending_reports [$];
  in_word_t    file_q [$];
  logic        row_typed = 1'b0;
  result_t     row_exp   = '0;
  bit          calm      = 1'b0;
  bit          hold_req  = 1'b0;
  int          mismatches = 0;
  int          reports_checked = 0;
  int          bytes_taken = 0;
  int          cycle_count = 0;
  int          status_seen [8];

  flac_stream_header_parser_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_start_req       (in_start_req),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_max_block_size (out_max_block_size),
    .out_min_frame_size (out_min_frame_size),
    .out_max_frame_size (out_max_frame_size),
    .out_sample_rate    (out_sample_rate),
    .out_channels       (out_channels),
    .out_sample_bits    (out_sample_bits),
    .out_total_samples  (out_total_samples),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic result_t unpack_streaminfo();
    logic [INFO_BITS-1:0] v;
    result_t r;
    logic [3:0] ch;
    logic [5:0] bits;
    int i;
    for (i = 0; i < INFO_BYTES; i++) v[INFO_BITS-1-8*i -: 8] = info_mem[i];
    ch   = {1'b0, v[INFO_BITS-1-CH_POS -: CH_LEN]} + 4'd1;
    bits = {1'b0, v[INFO_BITS-1-BITS_POS -: BITS_LEN]} + 6'd1;
    r = '0;
    r.max_block_size = v[INFO_BITS-1-MBS_POS -: MBS_LEN];
    r.min_frame_size = v[INFO_BITS-1-MINF_POS -: FRAME_LEN];
    r.max_frame_size = v[INFO_BITS-1-MAXF_POS -: FRAME_LEN];
    r.sample_rate    = v[INFO_BITS-1-RATE_POS -: RATE_LEN];
    r.total_samples  = v[INFO_BITS-1-TOT_POS -: TOT_LEN];
    r.channels       = ch;
    r.sample_bits    = bits;
    if (r.sample_rate == 0 || r.total_samples == 0 || bits < MIN_VALID_BITS)
      r.status = ST_BAD_FIELD;
    else if (ch < lim.min_channels || ch > lim.max_channels ||
             bits < lim.min_sample_bits || bits > lim.max_sample_bits)
      r.status = ST_LIMIT;
    else
      r.status = ST_OK;
    return r;
  endfunction

  task automatic flac_parse_byte(input logic [7:0] b, input logic st,
                                 output bit got, output result_t r);
    logic [23:0] size;
    got = 1'b0;
    r = '0;
    if (st) begin
      ph = PH_MAGIC;
      cnt = '0;
      last_blk = 1'b0;
      blk_kind = '0;
      hdr_sr = '0;
    end
    case (ph)
      PH_MAGIC: begin
        if (b != MAGIC_SEQ[cnt[1:0]]) begin
          got = 1'b1;
          r.status = ST_BAD_MAGIC;
          ph = PH_DONE;
        end else begin
          cnt = cnt + 24'd1;
          if (cnt >= MAGIC_LEN) begin
            ph = PH_HDR;
            cnt = '0;
          end
        end
      end
      PH_HDR: begin
        hdr_sr = {hdr_sr[23:0], b};
        cnt = cnt + 24'd1;
        if (cnt >= HDR_LEN) begin
          last_blk = hdr_sr[31];
          blk_kind = hdr_sr[30:24];
          size = hdr_sr[23:0];
          cnt = '0;
          if (size == 0) begin
            if (last_blk) begin
              got = 1'b1;
              r.status = ST_NO_INFO;
              ph = PH_DONE;
            end
          end else if (blk_kind == 0) begin
            ph = PH_INFO;
          end else begin
            ph = PH_SKIP;
            cnt = size;
          end
        end
      end
      PH_SKIP: begin
        cnt = cnt - 24'd1;
        if (cnt == 0) begin
          if (last_blk) begin
            got = 1'b1;
            r.status = ST_NO_INFO;
            ph = PH_DONE;
          end else begin
            ph = PH_HDR;
          end
        end
      end
      PH_INFO: begin
        if (cnt < INFO_BYTES) info_mem[cnt[4:0]] = b;
        cnt = cnt + 24'd1;
        if (cnt >= INFO_BYTES) begin
          got = 1'b1;
          r = unpack_streaminfo();
          ph = PH_DONE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [35:0] want,
                             input logic [35:0] seen);
    if (want !== seen) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin : watch
    bit got;
    result_t pr;
    result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_CH:   lim.min_channels    = cfg_data[3:0];
          CFG_MAX_CH:   lim.max_channels    = cfg_data[3:0];
          CFG_MIN_BITS: lim.min_sample_bits = cfg_data;
          CFG_MAX_BITS: lim.max_sample_bits = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        flac_parse_byte(in_data_byte, in_start_req, got, pr);
        bytes_taken++;
        if (got || row_typed) pending_reports.push_back(row_typed ? row_exp : pr);
      end
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected report, status %0d", $time, out_status);
        end else begin
          want = pending_reports.pop_front();
          check_field("status", 36'(want.status), 36'(out_status));
          check_field("max_block_size", 36'(want.max_block_size),
                      36'(out_max_block_size));
          check_field("min_frame_size", 36'(want.min_frame_size),
                      36'(out_min_frame_size));
          check_field("max_frame_size", 36'(want.max_frame_size),
                      36'(out_max_frame_size));
          check_field("sample_rate", 36'(want.sample_rate), 36'(out_sample_rate));
          check_field("channels", 36'(want.channels), 36'(out_channels));
          check_field("sample_bits", 36'(want.sample_bits), 36'(out_sample_bits));
          check_field("total_samples", want.total_samples, out_total_samples);
          status_seen[want.status]++;
          reports_checked++;
        end
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = rst_n && (calm || $urandom_range(0, 99) >= 19);
    end
  end

  task automatic send_word(input logic [7:0] b, input logic st, input logic typed,
                           input result_t typed_exp);
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_byte = b;
    in_start_req = st;
    row_typed    = typed;
    row_exp      = typed_exp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
  endtask

  task automatic apply_limits(input limits_t l);
    write_reg(CFG_MIN_CH, {2'b00, l.min_channels});
    write_reg(CFG_MAX_CH, {2'b00, l.max_channels});
    write_reg(CFG_MIN_BITS, l.min_sample_bits);
    write_reg(CFG_MAX_BITS, l.max_sample_bits);
    cfg_we = 1'b0;
  endtask

  task automatic put_word(input logic [7:0] b, input logic st);
    file_q.push_back(in_word_t'({b, st}));
  endtask

  task automatic put_random(input int n);
    repeat (n) put_word(8'($urandom), 1'b0);
  endtask

  task automatic put_magic(input int n_ok);
    logic [7:0] w;
    int i;
    for (i = 0; i < MAGIC_LEN; i++) begin
      w = MAGIC_SEQ[i];
      if (i >= n_ok) begin
        w = 8'($urandom);
        if (w == MAGIC_SEQ[i]) w = ~w;
      end
      put_word(w, i == 0);
      if (i >= n_ok) break;
    end
  endtask

  task automatic put_header(input logic last_flag, input logic [6:0] kind,
                            input logic [23:0] size);
    put_word({last_flag, kind}, 1'b0);
    put_word(size[23:16], 1'b0);
    put_word(size[15:8], 1'b0);
    put_word(size[7:0], 1'b0);
  endtask

  task automatic put_leading_blocks();
    int s;
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 3) == 0) begin
        put_header(1'b0, 7'($urandom), 24'd0);
      end else begin
        s = $urandom_range(1, 6);
        put_header(1'b0, 7'($urandom_range(1, 127)), 24'(s));
        put_random(s);
      end
    end
  endtask

  task automatic put_streaminfo();
    logic [INFO_BITS-1:0] v;
    logic [23:0] size;
    int m;
    int i;
    m = $urandom_range(0, 9);
    size = 24'd34;
    if (m >= 8) size = 24'($urandom);
    else if (m >= 6) size = 24'($urandom_range(1, INFO_BYTES - 1));
    if (size == 0) size = 24'd34;
    put_header(1'($urandom), 7'd0, size);
    v = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    m = $urandom_range(0, 99);
    if (m < 5) begin
      v = '1;
    end else if (m < 9) begin
      v = '0;
    end else begin
      if ($urandom_range(0, 99) < 8) v[INFO_BITS-1-RATE_POS -: RATE_LEN] = '0;
      if ($urandom_range(0, 99) < 8) v[INFO_BITS-1-TOT_POS -: TOT_LEN] = '0;
      if ($urandom_range(0, 99) < 65)
        v[INFO_BITS-1-BITS_POS -: BITS_LEN] = 5'($urandom_range(7, 23));
    end
    for (i = 0; i < INFO_BYTES; i++) put_word(v[INFO_BITS-1-8*i -: 8], 1'b0);
  endtask

  task automatic build_file();
    int k;
    int s;
    file_q.delete();
    k = $urandom_range(0, 99);
    if (k < 60) begin
      put_magic(MAGIC_LEN);
      put_leading_blocks();
      put_streaminfo();
      put_random($urandom_range(0, 4));
    end else if (k < 70) begin
      put_magic(MAGIC_LEN);
      put_leading_blocks();
      s = $urandom_range(0, 5);
      put_header(1'b1, 7'($urandom_range(1, 127)), 24'(s));
      put_random(s + $urandom_range(0, 3));
    end else if (k < 80) begin
      put_magic($urandom_range(0, MAGIC_LEN - 1));
      put_random($urandom_range(0, 4));
    end else if (k < 88) begin
      put_magic(MAGIC_LEN);
      put_leading_blocks();
      put_streaminfo();
      s = $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > s) void'(file_q.pop_back());
    end else if (k < 93) begin
      put_magic(MAGIC_LEN);
      put_header(1'($urandom), 7'($urandom_range(1, 127)), 24'($urandom) | 24'h000100);
      put_random($urandom_range(1, 8));
    end else begin
      repeat ($urandom_range(1, 10)) put_word(8'($urandom), $urandom_range(0, 4) == 0);
    end
  endtask

  initial begin
    dir_row_t row;
    result_t typed_exp;
    limits_t l;
    int i;
    int p;
    int phase_words;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    in_start_req = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_MIN_CH;
    cfg_data     = 6'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      typed_exp = '0;
      typed_exp.status = row.code;
      send_word(row.b, row.st, row.typed, typed_exp);
    end
    settle();

    for (p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        settle();
        if (p <= $size(LIMIT_SETS)) begin
          l = LIMIT_SETS[p-1];
        end else begin
          l.min_channels    = 4'($urandom_range(1, 8));
          l.max_channels    = 4'($urandom_range(1, 8));
          l.min_sample_bits = 6'($urandom_range(1, 32));
          l.max_sample_bits = 6'($urandom_range(1, 32));
        end
        apply_limits(l);
      end
      calm = (p == 2);
      if (p == 0) hold_req = 1'b1;
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        build_file();
        foreach (file_q[i]) send_word(file_q[i].data_byte, file_q[i].start_req, 1'b0, '0);
        phase_words += file_q.size();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Parsed %0d bytes under %0d limit settings, %0d reports checked",
             bytes_taken, N_PHASES, reports_checked);
    $display("Reports: ok %0d, bad magic %0d, no streaminfo %0d, bad fields %0d, limits %0d",
             status_seen[ST_OK], status_seen[ST_BAD_MAGIC], status_seen[ST_NO_INFO],
             status_seen[ST_BAD_FIELD], status_seen[ST_LIMIT]);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
